// File: rtl/content_type_header_parser_defines.svh
// ----------------------------------------------------------------------------
// Content-Type header parser assertion macros
// Concurrent assertion wrappers used by the parser's result queue.
// ----------------------------------------------------------------------------
`ifndef CONTENT_TYPE_HEADER_PARSER_DEFINES_SVH
`define CONTENT_TYPE_HEADER_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
`define CTP_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("content_type_header_parser assertion failed");
`define CTP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("content_type_header_parser assertion failed");
`else
`define CTP_ASSERT(label, clk, rst_n, prop)
`define CTP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/ctp_pkg.sv
// ----------------------------------------------------------------------------
// ctp_pkg
// Types, constants and helper functions of the Content-Type header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ctp_pkg;

	localparam int TYPE_MAX    = 128;
	localparam int CHARSET_MAX = 32;

	localparam int CHAR_W  = 8;
	localparam int KIND_W  = 2;
	localparam int TCNT_W  = 8;
	localparam int CCNT_W  = 6;
	localparam int PHASE_W = 3;
	localparam int POS_W   = 3;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [KIND_W-1:0] KIND_TYPE    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CHARSET = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END     = 2'd2;

	localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
	localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
	localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

	localparam logic [POS_W-1:0] NAME_LEN = 3'd7;

	typedef struct packed {
		logic [CHAR_W-1:0] char_val;
		logic [KIND_W-1:0] kind;
		logic [TCNT_W-1:0] type_count;
		logic [CCNT_W-1:0] charset_count;
		logic              is_last;
	} result_t;

	typedef struct packed {
		logic [1:0] num;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic logic is_ws(input logic [CHAR_W-1:0] c);
		is_ws = (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			to_lower = c + 8'd32;
		end else begin
			to_lower = c;
		end
	endfunction

	function automatic logic [CHAR_W-1:0] name_char(input logic [POS_W-1:0] pos);
		case (pos)
			3'd0: name_char = 8'h63;
			3'd1: name_char = 8'h68;
			3'd2: name_char = 8'h61;
			3'd3: name_char = 8'h72;
			3'd4: name_char = 8'h73;
			3'd5: name_char = 8'h65;
			3'd6: name_char = 8'h74;
			default: name_char = 8'h00;
		endcase
	endfunction

endpackage

`default_nettype wire

// File: rtl/content_type_header_parser.sv
// ----------------------------------------------------------------------------
// content_type_header_parser
// Streams a Content-Type header byte by byte and emits the lowercased media
// type, the charset value and one end transaction per header.
// ----------------------------------------------------------------------------
// The block takes one header byte per clock while in_stall is low. Each byte
// is registered, decoded by the phase machine and its results (the byte's own
// media-type or charset transaction, plus the end transaction when last_byte
// is set) are written into a four-entry result queue. A result reaches the
// output through the input register and the result queue. The queue drains one
// transaction per cycle while out_stall is low, so the input stalls only while
// the queue holds more than two results, which happens when end transactions
// arrive faster than one output per cycle or the output side stalls.
`default_nettype none

module content_type_header_parser import ctp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [CHAR_W-1:0] byte_in,
	input  wire logic              last_byte,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [CHAR_W-1:0]      out_char,
	output logic [KIND_W-1:0]      out_kind,
	output logic [TCNT_W-1:0]      type_count,
	output logic [CCNT_W-1:0]      charset_count,
	output logic                   is_last
);

	push_t push;
	logic  room;

	ctp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.byte_in   (byte_in),
		.last_byte (last_byte),
		.room      (room),
		.push      (push)
	);

	ctp_result_fifo u_fifo (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.room          (room),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_char      (out_char),
		.out_kind      (out_kind),
		.type_count    (type_count),
		.charset_count (charset_count),
		.is_last       (is_last)
	);

endmodule

`default_nettype wire

// File: rtl/ctp_parser.sv
// ----------------------------------------------------------------------------
// ctp_parser
// Input register and per-byte phase machine; produces up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module ctp_parser import ctp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [CHAR_W-1:0] byte_in,
	input  wire logic              last_byte,
	input  wire logic              room,
	output push_t                  push
);

	localparam logic [PHASE_W-1:0] PH_TYPE  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_SEEK  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_MATCH = 3'd2;
	localparam logic [PHASE_W-1:0] PH_SKIP  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_SP1   = 3'd4;
	localparam logic [PHASE_W-1:0] PH_SP2   = 3'd5;
	localparam logic [PHASE_W-1:0] PH_VALUE = 3'd6;
	localparam logic [PHASE_W-1:0] PH_DONE  = 3'd7;

	logic              valid_s1;
	logic [CHAR_W-1:0] byte_s1;
	logic              last_s1;

	logic [PHASE_W-1:0] phase_q, phase_n;
	logic [POS_W-1:0]   pos_q, pos_n;
	logic [TCNT_W-1:0]  tkept_q, tkept_n;
	logic [CCNT_W-1:0]  ckept_q, ckept_n;
	logic               quoted_q, quoted_n;

	logic              consume;
	logic              emit;
	logic [KIND_W-1:0] emit_kind;
	logic [CHAR_W-1:0] lc;
	result_t           byte_item;
	result_t           end_item;

	assign in_stall = valid_s1 && !room;
	assign consume  = valid_s1 && room;
	assign lc       = to_lower(byte_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= byte_in;
			last_s1 <= last_byte;
		end
	end

	always_comb begin
		phase_n   = phase_q;
		pos_n     = pos_q;
		tkept_n   = tkept_q;
		ckept_n   = ckept_q;
		quoted_n  = quoted_q;
		emit      = 1'b0;
		emit_kind = KIND_CHARSET;
		if (byte_s1 == CH_NUL) begin
			phase_n = PH_DONE;
		end else begin
			case (phase_q)
				PH_TYPE: begin
					if (is_ws(byte_s1)) begin
						phase_n = PH_TYPE;
					end else if (byte_s1 == CH_SEMI) begin
						phase_n = PH_SEEK;
					end else if (tkept_q < TCNT_W'(TYPE_MAX)) begin
						tkept_n   = tkept_q + 1'b1;
						emit      = 1'b1;
						emit_kind = KIND_TYPE;
					end
				end
				PH_SEEK: begin
					if (is_ws(byte_s1) || byte_s1 == CH_SEMI) begin
						phase_n = PH_SEEK;
					end else if (lc == name_char(3'd0)) begin
						pos_n   = 3'd1;
						phase_n = PH_MATCH;
					end else begin
						phase_n = PH_SKIP;
					end
				end
				PH_MATCH: begin
					if (lc == name_char(pos_q)) begin
						if (pos_q + 1'b1 == NAME_LEN) begin
							pos_n   = '0;
							phase_n = PH_SP1;
						end else begin
							pos_n = pos_q + 1'b1;
						end
					end else begin
						pos_n   = '0;
						phase_n = (byte_s1 == CH_SEMI) ? PH_SEEK : PH_SKIP;
					end
				end
				PH_SKIP: begin
					if (byte_s1 == CH_SEMI) begin
						phase_n = PH_SEEK;
					end
				end
				PH_SP1: begin
					if (is_ws(byte_s1)) begin
						phase_n = PH_SP1;
					end else if (byte_s1 == CH_EQ) begin
						phase_n = PH_SP2;
					end else begin
						phase_n = PH_DONE;
					end
				end
				PH_SP2: begin
					if (is_ws(byte_s1)) begin
						phase_n = PH_SP2;
					end else if (byte_s1 == CH_QUOTE) begin
						quoted_n = 1'b1;
						phase_n  = PH_VALUE;
					end else if (byte_s1 == CH_SEMI) begin
						phase_n = PH_DONE;
					end else begin
						quoted_n = 1'b0;
						phase_n  = PH_VALUE;
						if (ckept_q < CCNT_W'(CHARSET_MAX)) begin
							ckept_n = ckept_q + 1'b1;
							emit    = 1'b1;
						end
					end
				end
				PH_VALUE: begin
					if (quoted_q ? (byte_s1 == CH_QUOTE)
							: (byte_s1 == CH_SEMI || is_ws(byte_s1))) begin
						phase_n = PH_DONE;
					end else if (ckept_q < CCNT_W'(CHARSET_MAX)) begin
						ckept_n = ckept_q + 1'b1;
						emit    = 1'b1;
					end
				end
				default: begin
					phase_n = PH_DONE;
				end
			endcase
		end
	end

	always_comb begin
		byte_item.char_val      = lc;
		byte_item.kind          = emit_kind;
		byte_item.type_count    = tkept_n;
		byte_item.charset_count = ckept_n;
		byte_item.is_last       = 1'b0;
		end_item.char_val       = CH_NUL;
		end_item.kind           = KIND_END;
		end_item.type_count     = tkept_n;
		end_item.charset_count  = ckept_n;
		end_item.is_last        = 1'b1;
		push.r0  = emit ? byte_item : end_item;
		push.r1  = end_item;
		push.num = consume ? ({1'b0, emit} + {1'b0, last_s1}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TYPE;
			pos_q    <= '0;
			tkept_q  <= '0;
			ckept_q  <= '0;
			quoted_q <= 1'b0;
		end else if (consume) begin
			if (last_s1) begin
				phase_q  <= PH_TYPE;
				pos_q    <= '0;
				tkept_q  <= '0;
				ckept_q  <= '0;
				quoted_q <= 1'b0;
			end else begin
				phase_q  <= phase_n;
				pos_q    <= pos_n;
				tkept_q  <= tkept_n;
				ckept_q  <= ckept_n;
				quoted_q <= quoted_n;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/ctp_result_fifo.sv
// ----------------------------------------------------------------------------
// ctp_result_fifo
// Four-entry result queue; takes up to two results a cycle, gives one while out_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

`include "content_type_header_parser_defines.svh"

module ctp_result_fifo import ctp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire push_t             push,
	output logic                   room,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [CHAR_W-1:0]      out_char,
	output logic [KIND_W-1:0]      out_kind,
	output logic [TCNT_W-1:0]      type_count,
	output logic [CCNT_W-1:0]      charset_count,
	output logic                   is_last
);

	result_t           entry_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              pop;
	result_t           head;

	assign pop       = out_valid && !out_stall;
	assign out_valid = (count_q != '0);
	assign room      = (count_q <= CNT_W'(FIFO_DEPTH - 2));
	assign head      = entry_q[rd_ptr_q];

	assign out_char      = head.char_val;
	assign out_kind      = head.kind;
	assign type_count    = head.type_count;
	assign charset_count = head.charset_count;
	assign is_last       = head.is_last;

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			entry_q[wr_ptr_q] <= push.r0;
		end
		if (push.num == 2'd2) begin
			entry_q[wr_ptr_q + 1'b1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.num);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + CNT_W'(push.num) - CNT_W'(pop);
		end
	end

	`CTP_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(FIFO_DEPTH))
	`CTP_ASSERT(a_push_fits, clk, arst_n, !(push.num != 2'd0 && !room))
	`CTP_ASSERT(a_push_num, clk, arst_n, push.num != 2'd3)
	`CTP_ASSERT_IMPL(a_drain, clk, arst_n, pop && push.num == 2'd0,
		count_q == $past(count_q) - 1'b1)

endmodule

`default_nettype wire
